// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the deque.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/rdq_pkg.sv -----
// Types and codes of the ring deque.
package rdq_pkg;

  localparam int FUNC_W = 3;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [VAL_W-1:0]  value_t;

  localparam func_t FN_PUSH_FRONT = 3'd0;
  localparam func_t FN_PUSH_BACK  = 3'd1;
  localparam func_t FN_POP_FRONT  = 3'd2;
  localparam func_t FN_POP_BACK   = 3'd3;
  localparam func_t FN_DUMP       = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ----- hw/rtl/ring_deque.sv -----
// Ring deque top level: bounded double-ended queue in a circular slot memory.
//
// A bounded double-ended queue of signed 32-bit values held in a DEPTH-entry
// circular memory with one write port and one registered read port. Each input
// request carries an operation in s_tuser (push front, push back, pop front,
// pop back, dump) and a push value in s_tdata. Every request yields one result
// with m_tlast set, except a dump of a non-empty store, which yields one result
// per stored element from front to back and sets m_tlast on the final one.
// A push into a full store gives status full and changes nothing; a pop from or
// dump of an empty store gives status empty. Push, pop and the other codes pass
// through the accept step in S_IDLE (memory write or read issue) and the S_RES
// step that forms the result from the registered read data; a new request is
// taken only once that result is loaded. A dump walks the store in S_DUMP, one
// element per cycle through the single read port while the output register is
// free, and takes no new request until its last element is loaded. The result
// sits in an output register, so the next request is accepted while it still
// waits for m_tready. The slot memory has no reset; only pushed slots are read.
module ring_deque #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata: push_value[31:0]
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,
  // s_tuser: func[2:0]
  input  rdq_pkg::func_t               s_tuser,
  // m_tdata: out_value[31:0], occupancy[$clog2(DEPTH+1)+31:32], zero fill
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [((32 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  // m_tuser: status[1:0]
  output rdq_pkg::status_t             m_tuser,
  output logic                         m_tlast
);
  import rdq_pkg::*;

  localparam int IW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = $clog2(2 * DEPTH);
  localparam int TDW = ((VAL_W + CW + 7) / 8) * 8;

  // Sequencer codes.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RES  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  // Slot memory and its registered read data.
  value_t mem [DEPTH];
  value_t rd_data;

  // Control state.
  logic [1:0]    state, state_next;
  logic [IW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] dump_addr, dump_addr_next;
  logic [CW-1:0] dump_left, dump_left_next;
  status_t       res_status, res_status_next;
  logic          res_pop, res_pop_next;

  // Output register.
  value_t        m_value;
  status_t       m_status;
  logic [CW-1:0] m_occ;
  logic          m_last;

  // Memory access controls.
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  // Result load controls.
  logic          out_free;
  logic          out_load;
  value_t        out_value_d;
  status_t       out_status_d;
  logic          out_last_d;

  // Slot arithmetic.
  logic          full, empty;
  logic [IW-1:0] front_inc, front_dec, dump_inc;
  logic [SW-1:0] back_sum, tail_sum;
  logic [IW-1:0] back_slot, tail_slot;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign dump_inc  = (dump_addr == IW'(DEPTH - 1)) ? '0 : dump_addr + IW'(1);

  // Slot just past the back, and the back element itself; both sums stay
  // below twice the depth, so one subtract wraps them.
  assign back_sum  = SW'(front) + SW'(count);
  assign tail_sum  = SW'(front) + SW'(count) - SW'(1);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
  assign tail_slot = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);

  // Output register may take a new result when empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  // Take a request only when the sequencer is idle; the output register
  // decouples this from the downstream side.
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    front_next      = front;
    count_next      = count;
    dump_addr_next  = dump_addr;
    dump_left_next  = dump_left;
    res_status_next = res_status;
    res_pop_next    = res_pop;
    mem_we          = 1'b0;
    mem_waddr       = front;
    rd_en           = 1'b0;
    rd_addr         = front;
    out_load        = 1'b0;
    out_value_d     = '0;
    out_status_d    = ST_OK;
    out_last_d      = 1'b1;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          // Default: form a single result in S_RES.
          state_next      = S_RES;
          res_status_next = ST_OK;
          res_pop_next    = 1'b0;
          case (s_tuser)
            FN_PUSH_FRONT: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = front_dec;
                front_next = front_dec;
                count_next = count + CW'(1);
              end
            end
            FN_PUSH_BACK: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = back_slot;
                count_next = count + CW'(1);
              end
            end
            FN_POP_FRONT: begin
              if (empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = front;
                res_pop_next = 1'b1;
                front_next   = front_inc;
                count_next   = count - CW'(1);
              end
            end
            FN_POP_BACK: begin
              if (empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = tail_slot;
                res_pop_next = 1'b1;
                count_next   = count - CW'(1);
              end
            end
            FN_DUMP: begin
              if (empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                // Prime the read of the front slot; walk the rest in S_DUMP.
                rd_en          = 1'b1;
                rd_addr        = front;
                dump_addr_next = front_inc;
                dump_left_next = count;
                state_next     = S_DUMP;
              end
            end
            default: begin
              // Unused codes: report ok with the store untouched.
            end
          endcase
        end
      end
      S_RES: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_value_d  = res_pop ? rd_data : '0;
          out_status_d = res_status;
          out_last_d   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DUMP: begin
        // Read data holds while stalled since no new read is issued.
        if (out_free) begin
          out_load     = 1'b1;
          out_value_d  = rd_data;
          out_status_d = ST_OK;
          out_last_d   = (dump_left == CW'(1));
          if (dump_left == CW'(1)) begin
            state_next = S_IDLE;
          end else begin
            rd_en          = 1'b1;
            rd_addr        = dump_addr;
            dump_addr_next = dump_inc;
            dump_left_next = dump_left - CW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Slot memory: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= s_tdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      front    <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload and per-request working registers.
  always_ff @(posedge clk) begin
    dump_addr  <= dump_addr_next;
    dump_left  <= dump_left_next;
    res_status <= res_status_next;
    res_pop    <= res_pop_next;
    if (out_load) begin
      m_value  <= out_value_d;
      m_status <= out_status_d;
      m_occ    <= count;
      m_last   <= out_last_d;
    end
  end

  assign m_tdata = TDW'({m_occ, m_value});
  assign m_tuser = m_status;
  assign m_tlast = m_last;

  // Checks.
  `include "assert_macros.svh"

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `ASSERT_NEXT(a_one_request, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPLIES(a_full_status, clk, rst, out_load && (out_status_d == ST_FULL), full)
  `ASSERT_IMPLIES(a_dump_nonempty, clk, rst, state == S_DUMP, !empty && (dump_left != '0))

endmodule
